// ===== sv/slpfr_pkg.sv =====
package slpfr_pkg;

    localparam int OP_W   = 3;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;
    localparam int POS_W  = 17;
    localparam int LEN_W  = 16;
    localparam int SUM_W  = 16;

    localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
    localparam logic [OP_W-1:0] OP_BYTE     = 3'd1;
    localparam logic [OP_W-1:0] OP_DETECT   = 3'd2;
    localparam logic [OP_W-1:0] OP_START    = 3'd3;
    localparam logic [OP_W-1:0] OP_SHUTDOWN = 3'd4;

    localparam logic [IDX_W-1:0] CFG_SETUP_WAIT = 2'd0;
    localparam logic [IDX_W-1:0] CFG_READY_WAIT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_STANDBY_TO = 2'd2;

    localparam logic [CFG_W-1:0] RST_SETUP_WAIT = 16'd100;
    localparam logic [CFG_W-1:0] RST_READY_WAIT = 16'd200;
    localparam logic [CFG_W-1:0] RST_STANDBY_TO = 16'd5000;

    localparam logic [2:0] PS_UNINIT  = 3'd0;
    localparam logic [2:0] PS_SETUP   = 3'd1;
    localparam logic [2:0] PS_STANDBY = 3'd2;
    localparam logic [2:0] PS_RWAIT   = 3'd3;
    localparam logic [2:0] PS_READY   = 3'd4;

    localparam logic [7:0] BYTE_READY = 8'h55;
    localparam logic [7:0] BYTE_HDR0  = 8'hEF;
    localparam logic [7:0] BYTE_HDR1  = 8'h01;

    localparam logic [POS_W-1:0] POS_HDR0    = 17'd0;
    localparam logic [POS_W-1:0] POS_HDR1    = 17'd1;
    localparam logic [POS_W-1:0] POS_IDENT   = 17'd6;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd7;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd8;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 17'd9;
    localparam logic [POS_W-1:0] POS_SUM_HI  = 17'd7;

    localparam logic [LEN_W-1:0] LEN_MIN = 16'd2;

    typedef enum logic [4:0] {
        MODE_UNINIT  = 5'b00001,
        MODE_SETUP   = 5'b00010,
        MODE_STANDBY = 5'b00100,
        MODE_RWAIT   = 5'b01000,
        MODE_READY   = 5'b10000
    } t_mode;

    typedef struct packed {
        logic       frame_done;
        logic       checksum_ok;
        logic [7:0] confirm_code;
        logic       ready_seen;
        logic       frame_error;
    } t_frm_res;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        case (m)
            MODE_UNINIT:  c = PS_UNINIT;
            MODE_SETUP:   c = PS_SETUP;
            MODE_STANDBY: c = PS_STANDBY;
            MODE_RWAIT:   c = PS_RWAIT;
            MODE_READY:   c = PS_READY;
            default:      c = PS_UNINIT;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/slpfr_deframer.sv =====
module slpfr_deframer
    import slpfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_en,
    input  logic [7:0] i_byte,
    input  logic       i_clear,
    output t_frm_res   o_res
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [LEN_W-1:0] r_len, n_len;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [7:0]       r_sum_hi, n_sum_hi;
    logic [7:0]       r_first, n_first;
    logic [POS_W-1:0] tail_pos;
    logic [LEN_W-1:0] len_lo;
    logic [SUM_W-1:0] sum_add;
    t_frm_res         res;

    assign tail_pos = POS_W'(r_len) + POS_SUM_HI;
    assign len_lo   = {r_len[LEN_W-1:8], i_byte};
    assign sum_add  = r_sum + SUM_W'(i_byte);

    always_comb begin
        n_pos    = r_pos;
        n_len    = r_len;
        n_sum    = r_sum;
        n_sum_hi = r_sum_hi;
        n_first  = r_first;
        res      = '0;
        if (i_clear) begin
            n_pos    = '0;
            n_len    = '0;
            n_sum    = '0;
            n_sum_hi = '0;
            n_first  = '0;
        end else if (i_byte_en) begin
            if (r_pos == POS_HDR0) begin
                if (i_byte == BYTE_READY) begin
                    res.ready_seen = 1'b1;
                end else if (i_byte != BYTE_HDR0) begin
                    res.frame_error = 1'b1;
                end else begin
                    n_pos = POS_HDR1;
                end
            end else if (r_pos == POS_HDR1) begin
                if (i_byte != BYTE_HDR1) begin
                    res.frame_error = 1'b1;
                    n_pos           = '0;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end else if (r_pos < POS_IDENT) begin
                n_pos = r_pos + 1'b1;
            end else if (r_pos < POS_PAYLOAD) begin
                n_sum = sum_add;
                n_pos = r_pos + 1'b1;
                if (r_pos == POS_LEN_HI) begin
                    n_len = {i_byte, 8'h00};
                end
                if (r_pos == POS_LEN_LO) begin
                    n_len = len_lo;
                    if (len_lo < LEN_MIN) begin
                        res.frame_error = 1'b1;
                        n_pos    = '0;
                        n_len    = '0;
                        n_sum    = '0;
                        n_sum_hi = '0;
                        n_first  = '0;
                    end
                end
            end else if (r_pos < tail_pos) begin
                n_sum = sum_add;
                n_pos = r_pos + 1'b1;
                if (r_pos == POS_PAYLOAD) begin
                    n_first = i_byte;
                end
            end else if (r_pos == tail_pos) begin
                n_sum_hi = i_byte;
                n_pos    = r_pos + 1'b1;
            end else begin
                res.frame_done   = 1'b1;
                res.checksum_ok  = ({r_sum_hi, i_byte} == r_sum);
                res.confirm_code = r_first;
                n_pos    = '0;
                n_len    = '0;
                n_sum    = '0;
                n_sum_hi = '0;
                n_first  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len    <= '0;
            r_sum    <= '0;
            r_sum_hi <= '0;
            r_first  <= '0;
        end else begin
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_sum    <= n_sum;
            r_sum_hi <= n_sum_hi;
            r_first  <= n_first;
        end
    end

    assign o_res = res;

endmodule

// ===== sv/sensor_link_power_and_frame_receiver.sv =====
// Sensor link power sequencer and reply-frame receiver.
// Input words arrive on s_axis: tuser carries the event opcode (tick, byte,
// detect, start, shutdown) and tdata the received serial byte.
// Every accepted word produces exactly one result word on m_axis, holding the
// power state, the enable level and the frame flags for that event.
// The three timing registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_wdata; write them only while no word is in flight.
// Each result word is registered and shows on m_axis in the cycle after its word is accepted.
// Throughput: one word per cycle while results are taken, set by the single result register.
// s_axis_tready stays high while the result register is empty or is being
// taken in the same cycle; when m_axis_tready is low with a result held,
// s_axis_tready drops and the result holds until taken.
// Reset (i_rst_n low, synchronous) loads the default timing values, puts the
// power machine in its uninitialized state with enable low, empties the
// frame receiver and the result register.
module sensor_link_power_and_frame_receiver
    import slpfr_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // rx_byte[7:0]
    input  logic [OP_W-1:0]  s_axis_tuser,   // opcode[2:0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // power_state[2:0], enable_out[3], frame_done[4], checksum_ok[5],
    // confirm_code[13:6], ready_seen[14], frame_error[15]
    output logic [15:0]      m_axis_tdata,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

    logic [CFG_W-1:0]       r_setup_wait, r_ready_wait, r_standby_to;
    t_mode                  r_mode, n_mode;
    logic                   r_en, n_en;
    logic [TIMER_WIDTH-1:0] r_elapsed, n_elapsed, elapsed_inc;
    logic [CFG_W-1:0]       thr;
    logic                   timeout;
    logic                   accept;
    logic                   byte_en, frm_clear;
    t_frm_res               frm_res;
    logic                   r_out_valid;
    logic [15:0]            r_out_data;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup_wait <= RST_SETUP_WAIT;
            r_ready_wait <= RST_READY_WAIT;
            r_standby_to <= RST_STANDBY_TO;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SETUP_WAIT: r_setup_wait <= i_cfg_wdata;
                CFG_READY_WAIT: r_ready_wait <= i_cfg_wdata;
                CFG_STANDBY_TO: r_standby_to <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;

    always_comb begin
        case (r_mode)
            MODE_SETUP: thr = r_setup_wait;
            MODE_RWAIT: thr = r_ready_wait;
            default:    thr = r_standby_to;
        endcase
    end

    assign timeout = CMP_W'(elapsed_inc) > CMP_W'(thr);

    always_comb begin
        n_mode    = r_mode;
        n_en      = r_en;
        n_elapsed = r_elapsed;
        byte_en   = 1'b0;
        frm_clear = 1'b0;
        if (accept) begin
            case (s_axis_tuser)
                OP_TICK: begin
                    case (r_mode)
                        MODE_SETUP: begin
                            n_elapsed = elapsed_inc;
                            if (timeout) begin
                                n_mode    = r_en ? MODE_RWAIT : MODE_STANDBY;
                                n_elapsed = '0;
                            end
                        end
                        MODE_STANDBY: n_en = 1'b0;
                        MODE_RWAIT: begin
                            n_en      = 1'b1;
                            n_elapsed = elapsed_inc;
                            if (timeout) begin
                                n_mode    = MODE_READY;
                                n_elapsed = '0;
                            end
                        end
                        MODE_READY: begin
                            n_elapsed = elapsed_inc;
                            if (timeout) begin
                                n_mode    = MODE_STANDBY;
                                n_en      = 1'b0;
                                n_elapsed = '0;
                                frm_clear = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_BYTE: byte_en = (r_mode == MODE_RWAIT) || (r_mode == MODE_READY);
                OP_DETECT: begin
                    if (r_mode == MODE_STANDBY) begin
                        n_en      = 1'b1;
                        n_mode    = MODE_RWAIT;
                        n_elapsed = '0;
                    end
                end
                OP_START: begin
                    if (r_mode == MODE_UNINIT) begin
                        n_en      = 1'b1;
                        n_mode    = MODE_SETUP;
                        n_elapsed = '0;
                    end
                end
                OP_SHUTDOWN: n_en = 1'b0;
                default: ;
            endcase
            if (frm_res.ready_seen) begin
                n_mode    = MODE_READY;
                n_elapsed = '0;
            end
        end
    end

    slpfr_deframer u_deframer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (byte_en),
        .i_byte    (s_axis_tdata),
        .i_clear   (frm_clear),
        .o_res     (frm_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_UNINIT;
            r_en        <= 1'b0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_en      <= n_en;
            r_elapsed <= n_elapsed;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {frm_res.frame_error, frm_res.ready_seen, frm_res.confirm_code,
                           frm_res.checksum_ok, frm_res.frame_done, n_en, mode_code(n_mode)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_standby_enable_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_STANDBY |-> !r_en)
        else $error("enable high in standby");

    a_uninit_timer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_UNINIT |-> r_elapsed == '0)
        else $error("timer moved before start");

    a_done_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[4] |-> !r_out_data[14] && !r_out_data[15])
        else $error("frame end flagged with ready or error");

    a_ok_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[5] |-> r_out_data[4])
        else $error("checksum ok without frame end");

    a_ready_byte_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && frm_res.ready_seen |=> r_mode == MODE_READY && r_elapsed == '0)
        else $error("ready byte did not enter ready");

endmodule
